// ===== src/cpid_pkg.sv =====
// shared types and constants for the column post image decoder
`timescale 1ns / 1ps

package cpid_pkg;

   localparam int unsigned OP_WIDTH = 2;
   localparam int unsigned COLUMN_WIDTH = 9;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned STATUS_WIDTH = 3;
   localparam int unsigned ADDR_WIDTH = 17;
   localparam int unsigned COLOR_WIDTH = 24;
   localparam int unsigned PIC_WIDTH_BITS = 10;
   localparam int unsigned PIC_HEIGHT_BITS = 9;
   localparam int unsigned ROW_WIDTH = 9;
   localparam int unsigned FLAT_ADDR_WIDTH = 12;
   localparam int unsigned PALETTE_SIZE = 256;

   localparam logic [PIC_WIDTH_BITS-1:0] MAX_WIDTH = 10'd512;
   localparam logic [PIC_HEIGHT_BITS-1:0] MAX_HEIGHT = 9'd256;
   localparam logic [FLAT_ADDR_WIDTH:0] FLAT_PIXELS = 13'd4096;
   localparam logic [PIC_WIDTH_BITS-1:0] WIDTH_RESET = 10'd64;
   localparam logic [PIC_HEIGHT_BITS-1:0] HEIGHT_RESET = 9'd64;
   localparam logic [BYTE_WIDTH-1:0] END_MARK = 8'hff;

   localparam logic [OP_WIDTH-1:0] OP_PALETTE_WRITE = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_COLUMN_START = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_COLUMN_BYTE = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_FLAT_BYTE = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] ST_CONSUMED = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_PIXEL = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_COLUMN_END = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_DROPPED = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_IGNORED = 3'd4;

   localparam logic CSR_PIC_WIDTH = 1'b0;
   localparam logic CSR_PIC_HEIGHT = 1'b1;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [ADDR_WIDTH-1:0]   address;
   } result_type;

endpackage

// ===== src/cpid_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module cpid_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cpid_parse.sv =====
// column post parser and flat address counter
`timescale 1ns / 1ps

module cpid_parse (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic [cpid_pkg::OP_WIDTH-1:0]         operation,
   input  logic [cpid_pkg::COLUMN_WIDTH-1:0]     column_index,
   input  logic [cpid_pkg::BYTE_WIDTH-1:0]       data_byte,
   input  logic [cpid_pkg::PIC_WIDTH_BITS-1:0]   pic_width,
   input  logic [cpid_pkg::PIC_HEIGHT_BITS-1:0]  pic_height,
   output cpid_pkg::result_type                  result
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_TOP = 3'd1;
   localparam logic [2:0] PH_LEN = 3'd2;
   localparam logic [2:0] PH_PAD1 = 3'd3;
   localparam logic [2:0] PH_PIX = 3'd4;
   localparam logic [2:0] PH_PAD2 = 3'd5;

   localparam int unsigned PROD_WIDTH = cpid_pkg::ROW_WIDTH + cpid_pkg::PIC_WIDTH_BITS;

   logic [2:0]                              phase_ff, phase_in;
   logic [cpid_pkg::COLUMN_WIDTH-1:0]       column_ff, column_in;
   logic [cpid_pkg::ROW_WIDTH-1:0]          row_ff, row_in;
   logic [cpid_pkg::BYTE_WIDTH-1:0]         left_ff, left_in;
   logic [cpid_pkg::ADDR_WIDTH-1:0]         running_ff, running_in;
   logic [cpid_pkg::FLAT_ADDR_WIDTH-1:0]    flat_ff, flat_in;
   logic [PROD_WIDTH-1:0]                   row_offset;
   logic [PROD_WIDTH-1:0]                   start_address;
   logic [cpid_pkg::FLAT_ADDR_WIDTH:0]      flat_inc;

   assign row_offset = {{cpid_pkg::PIC_WIDTH_BITS{1'b0}}, row_ff}
                     * {{cpid_pkg::ROW_WIDTH{1'b0}}, pic_width};
   assign start_address = row_offset
                        + {{(PROD_WIDTH-cpid_pkg::COLUMN_WIDTH){1'b0}}, column_ff};
   assign flat_inc = {1'b0, flat_ff} + 13'd1;

   always_comb begin
      phase_in = phase_ff;
      column_in = column_ff;
      row_in = row_ff;
      left_in = left_ff;
      running_in = running_ff;
      flat_in = flat_ff;
      result.status = cpid_pkg::ST_CONSUMED;
      result.address = '0;
      case (operation)
         cpid_pkg::OP_PALETTE_WRITE: begin
            result.status = cpid_pkg::ST_CONSUMED;
         end
         cpid_pkg::OP_COLUMN_START: begin
            column_in = column_index;
            phase_in = PH_TOP;
         end
         cpid_pkg::OP_FLAT_BYTE: begin
            result.status = cpid_pkg::ST_PIXEL;
            result.address = {{(cpid_pkg::ADDR_WIDTH-cpid_pkg::FLAT_ADDR_WIDTH){1'b0}},
                              flat_ff};
            flat_in = (flat_inc >= cpid_pkg::FLAT_PIXELS) ? '0
                      : flat_inc[cpid_pkg::FLAT_ADDR_WIDTH-1:0];
         end
         default: begin
            case (phase_ff)
               PH_TOP: begin
                  if (data_byte == cpid_pkg::END_MARK) begin
                     phase_in = PH_IDLE;
                     result.status = cpid_pkg::ST_COLUMN_END;
                  end else begin
                     row_in = {1'b0, data_byte};
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  left_in = data_byte;
                  phase_in = PH_PAD1;
               end
               PH_PAD1: begin
                  running_in = start_address[cpid_pkg::ADDR_WIDTH-1:0];
                  phase_in = (left_ff == '0) ? PH_PAD2 : PH_PIX;
               end
               PH_PIX: begin
                  row_in = row_ff + 9'd1;
                  running_in = running_ff
                             + {{(cpid_pkg::ADDR_WIDTH-cpid_pkg::PIC_WIDTH_BITS){1'b0}},
                                pic_width};
                  left_in = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     phase_in = PH_PAD2;
                  end
                  if (row_ff < pic_height) begin
                     result.status = cpid_pkg::ST_PIXEL;
                     result.address = running_ff;
                  end else begin
                     result.status = cpid_pkg::ST_DROPPED;
                  end
               end
               PH_PAD2: begin
                  phase_in = PH_TOP;
               end
               default: begin
                  result.status = cpid_pkg::ST_IGNORED;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         column_ff <= '0;
         row_ff <= '0;
         left_ff <= '0;
         running_ff <= '0;
         flat_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         column_ff <= column_in;
         row_ff <= row_in;
         left_ff <= left_in;
         running_ff <= running_in;
         flat_ff <= flat_in;
      end
   end

endmodule

// ===== src/column_post_image_decoder_top.sv =====
// top level of the column post image decoder: handshakes, config, palette ram
// an accepted request beat is registered in stage s1, then in the output register, and can stall on rsp_ready
// throughput: one beat per cycle while rsp_ready is high, limited by the single palette read port
// palette ram reads in the accept cycle; a write is visible to the next beat
// reset clears parser state, pipeline valids and config (width 64, height 64)
// palette contents are undefined after reset until written
`timescale 1ns / 1ps

module column_post_image_decoder_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [cpid_pkg::OP_WIDTH-1:0]         req_operation,
   input  logic [cpid_pkg::COLUMN_WIDTH-1:0]     req_column_index,
   input  logic [cpid_pkg::BYTE_WIDTH-1:0]       req_data_byte,
   input  logic [cpid_pkg::BYTE_WIDTH-1:0]       req_palette_index,
   input  logic [cpid_pkg::BYTE_WIDTH-1:0]       req_first_byte,
   input  logic [cpid_pkg::BYTE_WIDTH-1:0]       req_second_byte,
   input  logic [cpid_pkg::BYTE_WIDTH-1:0]       req_third_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cpid_pkg::STATUS_WIDTH-1:0]     rsp_status,
   output logic [cpid_pkg::ADDR_WIDTH-1:0]       rsp_pixel_address,
   output logic [cpid_pkg::COLOR_WIDTH-1:0]      rsp_pixel_color,
   input  logic                                  csr_write_enable,
   input  logic                                  csr_index,
   input  logic [cpid_pkg::PIC_WIDTH_BITS-1:0]   csr_write_data
);

   logic                                  accept;
   logic                                  s1_move;
   logic                                  s1_valid_ff, s1_valid_in;
   cpid_pkg::result_type                  s1_result_ff;
   cpid_pkg::result_type                  parse_result;
   logic                                  out_valid_ff, out_valid_in;
   logic [cpid_pkg::STATUS_WIDTH-1:0]     out_status_ff;
   logic [cpid_pkg::ADDR_WIDTH-1:0]       out_address_ff;
   logic [cpid_pkg::COLOR_WIDTH-1:0]      out_color_ff;
   logic [cpid_pkg::COLOR_WIDTH-1:0]      palette_color;
   logic [cpid_pkg::PIC_WIDTH_BITS-1:0]   width_ff, width_in;
   logic [cpid_pkg::PIC_HEIGHT_BITS-1:0]  height_ff, height_in;
   logic [cpid_pkg::PIC_HEIGHT_BITS-1:0]  height_data;

   assign s1_move = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept = req_valid && req_ready;

   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_ready);

   cpid_ram #(
      .WIDTH(cpid_pkg::COLOR_WIDTH),
      .DEPTH(cpid_pkg::PALETTE_SIZE)
   ) u_palette (
      .clock   (clock),
      .wr_en   (accept && (req_operation == cpid_pkg::OP_PALETTE_WRITE)),
      .wr_addr (req_palette_index),
      .wr_data ({req_third_byte, req_second_byte, req_first_byte}),
      .rd_en   (accept),
      .rd_addr (req_data_byte),
      .rd_data (palette_color)
   );

   cpid_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .operation    (req_operation),
      .column_index (req_column_index),
      .data_byte    (req_data_byte),
      .pic_width    (width_ff),
      .pic_height   (height_ff),
      .result       (parse_result)
   );

   // config writes saturate at the maximum picture size; height checks only the low 9 bits of the write data
   assign height_data = csr_write_data[cpid_pkg::PIC_HEIGHT_BITS-1:0];

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cpid_pkg::CSR_PIC_WIDTH: begin
               width_in = (csr_write_data > cpid_pkg::MAX_WIDTH) ? cpid_pkg::MAX_WIDTH
                          : csr_write_data;
            end
            cpid_pkg::CSR_PIC_HEIGHT: begin
               height_in = (height_data > cpid_pkg::MAX_HEIGHT) ? cpid_pkg::MAX_HEIGHT
                           : height_data;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         width_ff <= cpid_pkg::WIDTH_RESET;
         height_ff <= cpid_pkg::HEIGHT_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         width_ff <= width_in;
         height_ff <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff <= parse_result;
      end
      if (s1_move) begin
         out_status_ff <= s1_result_ff.status;
         out_address_ff <= s1_result_ff.address;
         out_color_ff <= (s1_result_ff.status == cpid_pkg::ST_PIXEL) ? palette_color : '0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_pixel_address = out_address_ff;
   assign rsp_pixel_color = out_color_ff;

endmodule
